[rtl/hcbd_pkg.sv]
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by hcbd_hex and http_chunked_body_decoder.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    // Size line progress
    typedef enum logic [1:0] {
        HS_LEAD   = 2'd0,
        HS_ZERO   = 2'd1,
        HS_DIGITS = 2'd2,
        HS_SKIP   = 2'd3
    } hex_stage_t;

endpackage

[rtl/hcbd_hex.sv]
// Size line byte parser: blank/prefix skipping and saturating hex accumulate.
// Depends on hcbd_pkg.
module hcbd_hex
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic [7:0]           data_byte,
    input  hex_stage_t           stage,
    input  logic [SIZE_BITS-1:0] count,
    output hex_stage_t           stage_next,
    output logic [SIZE_BITS-1:0] count_next
);

    logic                 is_num;
    logic                 is_alpha;
    logic                 hex_ok;
    logic                 blank;
    logic                 is_x;
    logic [3:0]           digit;
    logic                 sat;
    logic [SIZE_BITS-1:0] acc;

    assign is_num   = (data_byte >= CH_DIG0) && (data_byte <= CH_DIG9);
    assign is_alpha = ((data_byte >= CH_LC_A) && (data_byte <= CH_LC_F)) ||
                      ((data_byte >= CH_UC_A) && (data_byte <= CH_UC_F));
    assign hex_ok   = is_num || is_alpha;
    assign digit    = is_num ? data_byte[3:0] : data_byte[3:0] + 4'd9;
    assign blank    = (data_byte == CH_SP) || (data_byte == CH_TAB) ||
                      (data_byte == CH_LF) || (data_byte == CH_VT) ||
                      (data_byte == CH_FF);
    assign is_x     = (data_byte == CH_LC_X) || (data_byte == CH_UC_X);

    // count*16+digit overflows exactly when the top nibble is non-zero
    assign sat = |count[SIZE_BITS-1:SIZE_BITS-4];
    assign acc = sat ? {SIZE_BITS{1'b1}} : {count[SIZE_BITS-5:0], digit};

    always_comb begin
        stage_next = stage;
        count_next = count;
        unique case (stage)
            HS_LEAD: begin
                if (!blank) begin
                    if (!hex_ok) begin
                        stage_next = HS_SKIP;
                    end else begin
                        count_next = acc;
                        stage_next = (digit == 4'd0) ? HS_ZERO : HS_DIGITS;
                    end
                end
            end
            HS_ZERO: begin
                if (is_x) begin
                    stage_next = HS_DIGITS;
                end else if (!hex_ok) begin
                    stage_next = HS_SKIP;
                end else begin
                    count_next = acc;
                    stage_next = HS_DIGITS;
                end
            end
            HS_DIGITS: begin
                if (!hex_ok) begin
                    stage_next = HS_SKIP;
                end else begin
                    count_next = acc;
                end
            end
            default: begin
                stage_next = stage;
            end
        endcase
    end

endmodule

[rtl/http_chunked_body_decoder.sv]
// Chunked body decoder: one result transaction per input byte.
// The result is registered and presented on the m_ side in the cycle after the input transaction.
// Throughput: one byte per cycle while m_tready is high; the output register is reloaded as it drains.
// Framing state updates in the same cycle the byte is taken.
// Reset: synchronous active-low aresetn returns to the size line, count zero.
// Depends on hcbd_pkg and hcbd_hex.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] payload_byte, [8] is_payload, [9] byte_taken,
                                   // [10] message_done, [11] framing_error, [15:12] zero
);

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_SIZE_LF  = 4'd1,
        PH_DATA     = 4'd2,
        PH_DATA_CR  = 4'd3,
        PH_DATA_LF  = 4'd4,
        PH_TRAILER  = 4'd5,
        PH_FINAL_LF = 4'd6,
        PH_DONE     = 4'd7,
        PH_ERROR    = 4'd8
    } phase_t;

    phase_t               phase_reg, phase_next;
    hex_stage_t           hex_stage_reg, hex_stage_next;
    logic [SIZE_BITS-1:0] count_reg, count_next;
    hex_stage_t           hex_stage_upd;
    logic [SIZE_BITS-1:0] count_upd;
    logic [SIZE_BITS-1:0] count_dec;

    logic                 m_tvalid_reg;
    logic [7:0]           payload_reg, payload_next;
    logic                 is_payload_reg, is_payload_next;
    logic                 taken_reg, taken_next;
    logic                 done_reg;
    logic                 error_reg;
    logic                 s_fire;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, error_reg, done_reg, taken_reg, is_payload_reg, payload_reg};

    hcbd_hex #(
        .SIZE_BITS (SIZE_BITS)
    ) u_hex (
        .data_byte  (s_tdata),
        .stage      (hex_stage_reg),
        .count      (count_reg),
        .stage_next (hex_stage_upd),
        .count_next (count_upd)
    );

    assign count_dec = (count_reg != '0) ? count_reg - SIZE_BITS'(1) : count_reg;

    always_comb begin
        phase_next      = phase_reg;
        hex_stage_next  = hex_stage_reg;
        count_next      = count_reg;
        payload_next    = 8'h00;
        is_payload_next = 1'b0;
        taken_next      = 1'b1;
        unique case (phase_reg)
            PH_SIZE: begin
                if (s_tdata == CH_CR) begin
                    phase_next = PH_SIZE_LF;
                end else begin
                    hex_stage_next = hex_stage_upd;
                    count_next     = count_upd;
                end
            end
            PH_SIZE_LF: begin
                if (s_tdata != CH_LF) begin
                    phase_next = PH_ERROR;
                    taken_next = 1'b0;
                end else begin
                    hex_stage_next = HS_LEAD;
                    phase_next     = (count_reg == '0) ? PH_TRAILER : PH_DATA;
                end
            end
            PH_DATA: begin
                payload_next    = s_tdata;
                is_payload_next = 1'b1;
                count_next      = count_dec;
                if (count_dec == '0) begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (s_tdata != CH_CR) begin
                    phase_next = PH_ERROR;
                    taken_next = 1'b0;
                end else begin
                    phase_next = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (s_tdata != CH_LF) begin
                    phase_next = PH_ERROR;
                    taken_next = 1'b0;
                end else begin
                    phase_next     = PH_SIZE;
                    hex_stage_next = HS_LEAD;
                    count_next     = '0;
                end
            end
            PH_TRAILER: begin
                if (s_tdata == CH_CR) begin
                    phase_next = PH_FINAL_LF;
                end
            end
            PH_FINAL_LF: begin
                if (s_tdata != CH_LF) begin
                    phase_next = PH_ERROR;
                    taken_next = 1'b0;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                taken_next = 1'b0;
            end
            default: begin
                phase_next = PH_ERROR;
                taken_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            hex_stage_reg <= HS_LEAD;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                hex_stage_reg  <= hex_stage_next;
                count_reg      <= count_next;
                m_tvalid_reg   <= 1'b1;
                payload_reg    <= payload_next;
                is_payload_reg <= is_payload_next;
                taken_reg      <= taken_next;
                done_reg       <= (phase_next == PH_DONE);
                error_reg      <= (phase_next == PH_ERROR);
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // Done and error never coexist in one result
    a_done_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(done_reg && error_reg))
        else $error("done and error both set");

    // Payload bytes are always taken and only while framing is healthy
    a_payload_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && is_payload_reg) |-> (taken_reg && !done_reg && !error_reg))
        else $error("payload byte with bad status");

    // A byte is only refused once the message is finished or broken
    a_refusal_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !taken_reg) |-> (done_reg || error_reg))
        else $error("byte refused without cause");

    // Terminal phases are sticky until reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("left done phase");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR))
        else $error("left error phase");

endmodule
